/* hw/rtl/average_pool_2d_assert.svh */
// Assertion macros shared by the average pooling block.
`ifndef AVERAGE_POOL_2D_ASSERT_SVH
`define AVERAGE_POOL_2D_ASSERT_SVH

// Property holds on every clock edge outside reset.
`define AP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication in the next cycle outside reset.
`define AP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ap2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ap2d_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int MaxKernel = 8;
  localparam int AddrBits  = $clog2(MaxWidth * MaxHeight);
  localparam int ColBits   = $clog2(MaxWidth);
  localparam int RowBits   = $clog2(MaxHeight);
  localparam int SumBits   = 24;
  localparam int CntBits   = 7;

  localparam logic [2:0] RegKernelH = 3'd0;
  localparam logic [2:0] RegKernelW = 3'd1;
  localparam logic [2:0] RegStrideR = 3'd2;
  localparam logic [2:0] RegStrideC = 3'd3;
  localparam logic [2:0] RegPadTop  = 3'd4;
  localparam logic [2:0] RegPadLeft = 3'd5;
  localparam logic [2:0] RegCntPad  = 3'd6;

  typedef enum logic [2:0] {
    StIdle, StAcc, StAccLast, StDivInit, StDiv, StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // write the sample and update load counters
    logic win_init;    // reset tap counters and the sum
    logic tap_step;    // accumulate current tap, advance tap counters
    logic div_init;    // load the divider
    logic div_step;    // one quotient bit
    logic emit;        // present the result and advance the output position
    logic abandon;     // leave emission
  } ctrl_t;

  // Status from the datapath.
  typedef struct packed {
    logic emitting;
    logic have_out;    // next output is in range
    logic tap_last;    // current tap is the last one of the window
    logic div_done;
  } stat_t;

  // Floor of (span - k) / s + 1, clipped; span up to 78, s up to 15.
  function automatic logic [7:0] out_size(input logic [7:0] span, input logic [3:0] k,
                                          input logic [3:0] s);
    logic [7:0] d;
    logic [7:0] q;
    q = 8'd0;
    d = span - {4'd0, k};
    if (span < {4'd0, k}) return 8'd0;
    unique case (s)
      4'd1: q = d;
      4'd2: q = d >> 1;
      4'd4: q = d >> 2;
      4'd8: q = d >> 3;
      4'd3: q = 8'((16'(d) * 16'd171) >> 9);
      4'd5: q = 8'((16'(d) * 16'd205) >> 10);
      4'd6: q = 8'((16'(d) * 16'd171) >> 10);
      4'd7: q = 8'((16'(d) * 16'd293) >> 11);
      4'd9: q = 8'((16'(d) * 16'd456) >> 12);
      4'd10: q = 8'((16'(d) * 16'd410) >> 12);
      4'd11: q = 8'((16'(d) * 16'd373) >> 12);
      4'd12: q = 8'((16'(d) * 16'd342) >> 12);
      4'd13: q = 8'((16'(d) * 16'd316) >> 12);
      4'd14: q = 8'((16'(d) * 16'd293) >> 12);
      4'd15: q = 8'((16'(d) * 16'd274) >> 12);
      default: q = d;
    endcase
    return q + 8'd1;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/average_pool_2d.sv */
`timescale 1ns / 1ps
`default_nettype none
// 2-D average pooling over one plane of signed Q8.8 samples.
// Words enter on start while busy is low. cmd_i = 0 loads sample_i in row
// order; row_end_i and plane_end_i mark row and plane ends and fix the plane
// size (up to 64 by 64). A load gives no result and leaves the block idle.
// After the plane end, each cmd_i = 1 word computes the next output in row
// order. The window taps are walked one per cycle through the plane memory
// (one read port), then a restoring divider produces one quotient bit per
// cycle; busy stays high until the strobe. The result appears on average_o,
// out_row_o, out_col_o and last_o for exactly one cycle with strobe high;
// the receiver cannot stall it. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write it only while idle, as the
// block itself does not enforce this. Reset returns to the loading phase
// with default registers; the plane memory holds no reset value.
module average_pool_2d (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [3:0]         cfg_index_i,
  input  wire logic [3:0]         cfg_data_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               row_end_i,
  input  wire logic               plane_end_i,
  output logic                    strobe,
  output logic signed [15:0]      average_o,
  output logic [6:0]              out_row_o,
  output logic [6:0]              out_col_o,
  output logic                    last_o
);
  ap2d_pkg::ctrl_t ctrl;
  ap2d_pkg::stat_t stat;

  ap2d_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .cmd_i, .stat_i(stat),
    .ctrl_o(ctrl), .busy_o(busy), .strobe_o(strobe)
  );

  ap2d_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .sample_i, .row_end_i, .plane_end_i, .ctrl_i(ctrl), .stat_o(stat),
    .average_o, .out_row_o, .out_col_o, .last_o
  );
endmodule
`default_nettype wire

/* hw/rtl/ap2d_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "average_pool_2d_assert.svh"
module ap2d_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [3:0]          cfg_index_i,
  input  wire logic [3:0]          cfg_data_i,
  input  wire logic signed [15:0]  sample_i,
  input  wire logic                row_end_i,
  input  wire logic                plane_end_i,
  input  wire ap2d_pkg::ctrl_t     ctrl_i,
  output ap2d_pkg::stat_t          stat_o,
  output logic signed [15:0]       average_o,
  output logic [6:0]               out_row_o,
  output logic [6:0]               out_col_o,
  output logic                     last_o
);
  // Configuration registers.
  logic [3:0] kh_q, kw_q, sr_q, sc_q;
  logic [2:0] pt_q, pl_q;
  logic       cp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kh_q <= 4'd1; kw_q <= 4'd1; sr_q <= 4'd1; sc_q <= 4'd1;
      pt_q <= 3'd0; pl_q <= 3'd0; cp_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i[2:0])
        ap2d_pkg::RegKernelH: if (cfg_index_i[3] == 1'b0) kh_q <= cfg_data_i;
        ap2d_pkg::RegKernelW: if (cfg_index_i[3] == 1'b0) kw_q <= cfg_data_i;
        ap2d_pkg::RegStrideR: if (cfg_index_i[3] == 1'b0) sr_q <= cfg_data_i;
        ap2d_pkg::RegStrideC: if (cfg_index_i[3] == 1'b0) sc_q <= cfg_data_i;
        ap2d_pkg::RegPadTop:  if (cfg_index_i[3] == 1'b0) pt_q <= cfg_data_i[2:0];
        ap2d_pkg::RegPadLeft: if (cfg_index_i[3] == 1'b0) pl_q <= cfg_data_i[2:0];
        ap2d_pkg::RegCntPad:  if (cfg_index_i[3] == 1'b0) cp_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective kernel and stride after clamping.
  logic [3:0] kh, kw, sh, sw;
  assign kh = (kh_q == 4'd0) ? 4'd1 : (kh_q > 4'd8) ? 4'd8 : kh_q;
  assign kw = (kw_q == 4'd0) ? 4'd1 : (kw_q > 4'd8) ? 4'd8 : kw_q;
  assign sh = (sr_q == 4'd0) ? 4'd1 : sr_q;
  assign sw = (sc_q == 4'd0) ? 4'd1 : sc_q;

  // Load position, plane size, output position.
  logic [6:0] ld_row_q, ld_col_q, pw_q, ph_q, orow_q, ocol_q;
  logic       emit_q;
  logic [7:0] oh_n, ow_n, oh_new, ow_new;
  logic [6:0] pw_new, ph_new;
  logic [6:0] lr, lc;
  logic       out_last;
  assign lr = (ctrl_i.load && emit_q) ? 7'd0 : ld_row_q;
  assign lc = (ctrl_i.load && emit_q) ? 7'd0 : ld_col_q;
  assign pw_new = (lc < 7'd64) ? lc + 7'd1 : 7'd64;
  assign ph_new = (lr < 7'd64) ? lr + 7'd1 : 7'd64;
  assign oh_n   = ap2d_pkg::out_size(8'(ph_q) + 8'(pt_q) * 8'd2, kh, sh);
  assign ow_n   = ap2d_pkg::out_size(8'(pw_q) + 8'(pl_q) * 8'd2, kw, sw);
  assign oh_new = ap2d_pkg::out_size(8'(ph_new) + 8'(pt_q) * 8'd2, kh, sh);
  assign ow_new = ap2d_pkg::out_size(8'(pw_new) + 8'(pl_q) * 8'd2, kw, sw);
  assign out_last = ({1'b0, orow_q} == oh_n - 8'd1) && ({1'b0, ocol_q} == ow_n - 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_row_q <= '0; ld_col_q <= '0; pw_q <= '0; ph_q <= '0;
      orow_q <= '0; ocol_q <= '0; emit_q <= 1'b0;
    end else if (ctrl_i.load) begin
      if (row_end_i || plane_end_i) begin
        pw_q     <= pw_new;
        ld_col_q <= '0;
        if (plane_end_i) begin
          ph_q     <= ph_new;
          ld_row_q <= '0;
          orow_q   <= '0;
          ocol_q   <= '0;
          emit_q   <= (oh_new != 8'd0) && (ow_new != 8'd0);
        end else begin
          emit_q   <= 1'b0;
          ld_row_q <= (lr < 7'd64) ? lr + 7'd1 : lr;
        end
      end else begin
        emit_q   <= 1'b0;
        ld_row_q <= lr;
        ld_col_q <= (lc < 7'd64) ? lc + 7'd1 : lc;
      end
    end else if (ctrl_i.abandon) begin
      emit_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      if (out_last) begin
        emit_q <= 1'b0; orow_q <= '0; ocol_q <= '0;
      end else if ({1'b0, ocol_q} + 8'd1 >= ow_n) begin
        ocol_q <= '0; orow_q <= orow_q + 7'd1;
      end else begin
        ocol_q <= ocol_q + 7'd1;
      end
    end
  end

  // Plane memory with registered read.
  logic signed [15:0] mem [ap2d_pkg::MaxWidth * ap2d_pkg::MaxHeight];
  logic signed [15:0] rd_q;
  logic [ap2d_pkg::AddrBits-1:0] rd_addr;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && lr < 7'd64 && lc < 7'd64) begin
      mem[{lr[ap2d_pkg::RowBits-1:0], lc[ap2d_pkg::ColBits-1:0]}] <= sample_i;
    end
    rd_q <= mem[rd_addr];
  end

  // Tap walk: tap position is computed, memory read, then accumulated.
  logic [2:0] tr_q, tc_q;
  logic signed [9:0] ih, iw;
  logic              inside_now, inside_q, valid_q;
  assign ih = $signed(10'(orow_q) * 10'(sh) + 10'(tr_q)) - $signed(10'(pt_q));
  assign iw = $signed(10'(ocol_q) * 10'(sw) + 10'(tc_q)) - $signed(10'(pl_q));
  assign inside_now = (ih >= 0) && (ih < $signed({3'd0, ph_q})) &&
                      (iw >= 0) && (iw < $signed({3'd0, pw_q}));
  assign rd_addr = {ih[ap2d_pkg::RowBits-1:0], iw[ap2d_pkg::ColBits-1:0]};
  assign stat_o.tap_last = (tr_q == 3'(kh - 4'd1)) && (tc_q == 3'(kw - 4'd1));

  logic signed [ap2d_pkg::SumBits-1:0] sum_q;
  logic [ap2d_pkg::CntBits-1:0]        cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_q <= '0; tc_q <= '0; valid_q <= 1'b0; inside_q <= 1'b0;
      sum_q <= '0; cnt_q <= '0;
    end else begin
      valid_q  <= ctrl_i.tap_step;
      inside_q <= inside_now;
      if (valid_q) begin
        if (inside_q) begin
          sum_q <= sum_q + ap2d_pkg::SumBits'(rd_q);
          cnt_q <= cnt_q + 7'd1;
        end else if (cp_q) begin
          cnt_q <= cnt_q + 7'd1;
        end
      end
      if (ctrl_i.win_init) begin
        tr_q <= '0; tc_q <= '0; sum_q <= '0; cnt_q <= '0;
      end else if (ctrl_i.tap_step) begin
        if (tc_q == 3'(kw - 4'd1)) begin
          tc_q <= '0; tr_q <= tr_q + 3'd1;
        end else begin
          tc_q <= tc_q + 3'd1;
        end
      end
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [22:0] dividend_q, rem_q;
  logic [4:0]  dbit_q;
  logic        neg_q;
  logic [23:0] trial;
  assign trial = {rem_q, dividend_q[22]} - {17'd0, cnt_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dividend_q <= '0; rem_q <= '0; dbit_q <= '0; neg_q <= 1'b0;
    end else if (ctrl_i.div_init) begin
      neg_q      <= sum_q[ap2d_pkg::SumBits-1];
      dividend_q <= sum_q[ap2d_pkg::SumBits-1] ? 23'(-sum_q) : sum_q[22:0];
      rem_q      <= '0;
      dbit_q     <= 5'd23;
    end else if (ctrl_i.div_step) begin
      if (!trial[23]) begin
        rem_q <= trial[22:0];
      end else begin
        rem_q <= {rem_q[21:0], dividend_q[22]};
      end
      dividend_q <= {dividend_q[21:0], !trial[23]};
      dbit_q     <= dbit_q - 5'd1;
    end
  end
  assign stat_o.div_done = (dbit_q == 5'd0);

  logic [15:0] quo;
  assign quo = (cnt_q == '0) ? 16'd0 : neg_q ? 16'(-dividend_q) : dividend_q[15:0];

  // Result register, loaded on each emit.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      average_o <= quo;
      out_row_o <= orow_q;
      out_col_o <= ocol_q;
      last_o    <= out_last;
    end
  end

  assign stat_o.emitting = emit_q;
  assign stat_o.have_out = emit_q && (oh_n != 8'd0) && (ow_n != 8'd0) &&
                           ({1'b0, orow_q} < oh_n) && ({1'b0, ocol_q} < ow_n);

  `AP_ASSERT(a_tap_in_kernel, !ctrl_i.tap_step || ({1'b0, tr_q} < kh),
             "tap row beyond kernel")
  `AP_ASSERT_NEXT(a_load_ends_emit, ctrl_i.load && !plane_end_i, !emit_q,
                  "load did not leave emission")
  `AP_ASSERT(a_count_bound, cnt_q <= 7'd64, "tap count above window size")
endmodule
`default_nettype wire

/* hw/rtl/ap2d_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "average_pool_2d_assert.svh"
module ap2d_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            cmd_i,
  input  wire ap2d_pkg::stat_t stat_i,
  output ap2d_pkg::ctrl_t      ctrl_o,
  output logic                 busy_o,
  output logic                 strobe_o
);
  ap2d_pkg::state_e state_q, state_d;
  logic strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ap2d_pkg::StIdle;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= ctrl_o.emit;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ap2d_pkg::StIdle: begin
        if (start_i) begin
          if (!cmd_i) begin
            ctrl_o.load = 1'b1;
          end else if (stat_i.have_out) begin
            ctrl_o.win_init = 1'b1;
            state_d = ap2d_pkg::StAcc;
          end else begin
            ctrl_o.abandon = 1'b1;
          end
        end
      end
      ap2d_pkg::StAcc: begin
        ctrl_o.tap_step = 1'b1;
        if (stat_i.tap_last) state_d = ap2d_pkg::StAccLast;
      end
      ap2d_pkg::StAccLast: state_d = ap2d_pkg::StDivInit;
      ap2d_pkg::StDivInit: begin
        ctrl_o.div_init = 1'b1;
        state_d = ap2d_pkg::StDiv;
      end
      ap2d_pkg::StDiv: begin
        if (stat_i.div_done) begin
          state_d = ap2d_pkg::StOut;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      ap2d_pkg::StOut: begin
        ctrl_o.emit = 1'b1;
        state_d = ap2d_pkg::StIdle;
      end
      default: state_d = ap2d_pkg::StIdle;
    endcase
  end

  assign busy_o   = (state_q != ap2d_pkg::StIdle);
  assign strobe_o = strobe_q;

  `AP_ASSERT_NEXT(a_emit_strobe, ctrl_o.emit, strobe_o, "result strobe missing")
  `AP_ASSERT(a_one_cmd, $onehot0(ctrl_o), "more than one command at once")
  `AP_ASSERT_NEXT(a_out_to_idle, state_q == ap2d_pkg::StOut, !busy_o,
                  "busy after result")
endmodule
`default_nettype wire

/* dv/ap2d_checker.sv */
`timescale 1ns / 1ps
// Watches the pooling block's ports, predicts each output word and compares it.
module ap2d_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               start,
  input  logic               busy,
  input  logic               cmd_i,
  input  logic signed [15:0] sample_i,
  input  logic               row_end_i,
  input  logic               plane_end_i,
  input  logic               strobe,
  input  logic signed [15:0] average_o,
  input  logic [6:0]         out_row_o,
  input  logic [6:0]         out_col_o,
  input  logic               last_o,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] average;
    logic [6:0]         out_row;
    logic [6:0]         out_col;
    logic               last;
  } pool_word_t;

  pool_word_t         avg_q[$];
  logic signed [15:0] plane_mem [0:ap2d_pkg::MaxWidth*ap2d_pkg::MaxHeight-1];
  logic [3:0]         k_rows, k_cols, s_rows, s_cols;
  logic [2:0]         p_rows, p_cols;
  logic               cnt_pad;
  int                 ld_row, ld_col, p_width, p_height, o_row, o_col;
  logic               emitting;

  function automatic int clip_k(logic [3:0] k);
    if (k == 0) return 1;
    return (k > ap2d_pkg::MaxKernel) ? ap2d_pkg::MaxKernel : int'(k);
  endfunction

  function automatic int windows(int span_in, int pad, int k, int s);
    int span;
    int n;
    span = span_in + 2 * pad;
    if (span < k) return 0;
    n = (span - k) / s + 1;
    return (n > 128) ? 128 : n;
  endfunction

  // Average of the window at the current output position.
  function automatic logic signed [15:0] window_average(int kh, int kw, int sh, int sw);
    longint sum;
    longint cnt;
    int     ih, iw;
    sum = 0;
    cnt = 0;
    for (int r = 0; r < kh; r++) begin
      for (int c = 0; c < kw; c++) begin
        ih = o_row * sh + r - int'(p_rows);
        iw = o_col * sw + c - int'(p_cols);
        if (ih >= 0 && ih < p_height && iw >= 0 && iw < p_width) begin
          sum += longint'(plane_mem[ih * ap2d_pkg::MaxWidth + iw]);
          cnt++;
        end else if (cnt_pad) begin
          cnt++;
        end
      end
    end
    return (cnt > 0) ? 16'(sum / cnt) : 16'sd0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int         kh, kw, sh, sw, oh_n, ow_n;
    int         errs;
    pool_word_t w;
    errs = 0;
    if (!rst_ni) begin
      avg_q.delete();
      fail_count <= 0;
      pending    <= 0;
      k_rows = 1; k_cols = 1; s_rows = 1; s_cols = 1;
      p_rows = 0; p_cols = 0; cnt_pad = 0;
      ld_row = 0; ld_col = 0; p_width = 0; p_height = 0;
      o_row = 0; o_col = 0; emitting = 0;
    end else begin
      // Compare an output word against the oldest prediction.
      if (strobe) begin
        if (avg_q.size() == 0) begin
          $error("output word with none expected");
          errs++;
        end else begin
          w = avg_q.pop_front();
          if (average_o !== w.average) begin
            $error("average: expected %0d, got %0d", w.average, average_o);
            errs++;
          end
          if (out_row_o !== w.out_row) begin
            $error("out_row: expected %0d, got %0d", w.out_row, out_row_o);
            errs++;
          end
          if (out_col_o !== w.out_col) begin
            $error("out_col: expected %0d, got %0d", w.out_col, out_col_o);
            errs++;
          end
          if (last_o !== w.last) begin
            $error("last: expected %0d, got %0d", w.last, last_o);
            errs++;
          end
        end
      end

      // Register writes; indexes past the list are ignored.
      if (cfg_we_i && !cfg_index_i[3]) begin
        case (cfg_index_i[2:0])
          ap2d_pkg::RegKernelH: k_rows = cfg_data_i;
          ap2d_pkg::RegKernelW: k_cols = cfg_data_i;
          ap2d_pkg::RegStrideR: s_rows = cfg_data_i;
          ap2d_pkg::RegStrideC: s_cols = cfg_data_i;
          ap2d_pkg::RegPadTop:  p_rows = cfg_data_i[2:0];
          ap2d_pkg::RegPadLeft: p_cols = cfg_data_i[2:0];
          ap2d_pkg::RegCntPad:  cnt_pad = cfg_data_i[0];
          default: ;
        endcase
      end

      // Accepted command word.
      if (start && !busy) begin
        kh = clip_k(k_rows);
        kw = clip_k(k_cols);
        sh = (s_rows == 0) ? 1 : int'(s_rows);
        sw = (s_cols == 0) ? 1 : int'(s_cols);
        if (!cmd_i) begin
          if (emitting) begin
            emitting = 0;
            ld_row = 0;
            ld_col = 0;
          end
          if (ld_row < ap2d_pkg::MaxHeight && ld_col < ap2d_pkg::MaxWidth)
            plane_mem[ld_row * ap2d_pkg::MaxWidth + ld_col] = sample_i;
          if (row_end_i || plane_end_i) begin
            p_width = (ld_col < ap2d_pkg::MaxWidth) ? ld_col + 1 : ap2d_pkg::MaxWidth;
            ld_col = 0;
            if (plane_end_i) begin
              p_height = (ld_row < ap2d_pkg::MaxHeight) ? ld_row + 1 : ap2d_pkg::MaxHeight;
              ld_row = 0;
              o_row = 0;
              o_col = 0;
              emitting = windows(p_height, p_rows, kh, sh) > 0 &&
                         windows(p_width, p_cols, kw, sw) > 0;
            end else if (ld_row < ap2d_pkg::MaxHeight) begin
              ld_row++;
            end
          end else if (ld_col < ap2d_pkg::MaxWidth) begin
            ld_col++;
          end
        end else begin
          oh_n = windows(p_height, p_rows, kh, sh);
          ow_n = windows(p_width, p_cols, kw, sw);
          if (!emitting || oh_n == 0 || ow_n == 0 || o_row >= oh_n || o_col >= ow_n) begin
            emitting = 0;
          end else begin
            w.average = window_average(kh, kw, sh, sw);
            w.out_row = 7'(o_row);
            w.out_col = 7'(o_col);
            w.last    = (o_row == oh_n - 1) && (o_col == ow_n - 1);
            avg_q.push_back(w);
            if (w.last) begin
              emitting = 0;
              o_row = 0;
              o_col = 0;
            end else if (o_col + 1 >= ow_n) begin
              o_col = 0;
              o_row++;
            end else begin
              o_col++;
            end
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= avg_q.size();
    end
  end

endmodule

/* dv/tb_average_pool_2d.sv */
`timescale 1ns / 1ps
// Drives planes and output requests into the pooling block under changing settings.
module tb_average_pool_2d;

  localparam int CycleLimit = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [3:0]         cfg_index_i = '0;
  logic [3:0]         cfg_data_i = '0;
  logic               start = 1'b0;
  logic               busy;
  logic               cmd_i = 1'b0;
  logic signed [15:0] sample_i = '0;
  logic               row_end_i = 1'b0;
  logic               plane_end_i = 1'b0;
  logic               strobe;
  logic signed [15:0] average_o;
  logic [6:0]         out_row_o, out_col_o;
  logic               last_o;
  int                 fail_count, pending;
  int                 cycles = 0;
  int                 words_sent = 0;
  logic               gaps_on = 1'b1;
  logic [3:0]         cur_cfg [0:6];

  average_pool_2d dut (.*);
  ap2d_checker u_checker (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_average_pool_2d failed");
      $finish;
    end
  end

  // Sends one word; returns at the edge that accepts it.
  task automatic send_word(logic c, logic [15:0] s, logic re, logic pe);
    while (gaps_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= c;
    sample_i    <= s;
    row_end_i   <= re;
    plane_end_i <= pe;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    words_sent++;
  endtask

  // Waits until every predicted word has come, then lets the block settle.
  task automatic drain();
    start <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_config(int kh, int kw, int sr, int sc, int pt, int pl, int cp);
    cur_cfg[ap2d_pkg::RegKernelH] = 4'(kh);
    cur_cfg[ap2d_pkg::RegKernelW] = 4'(kw);
    cur_cfg[ap2d_pkg::RegStrideR] = 4'(sr);
    cur_cfg[ap2d_pkg::RegStrideC] = 4'(sc);
    cur_cfg[ap2d_pkg::RegPadTop]  = 4'(pt);
    cur_cfg[ap2d_pkg::RegPadLeft] = 4'(pl);
    cur_cfg[ap2d_pkg::RegCntPad]  = 4'(cp);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 4'(i);
      cfg_data_i  <= cur_cfg[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic int axis_outputs(int n, logic [3:0] pad, logic [3:0] k, logic [3:0] s);
    int kk, ss, span;
    kk = (k == 0) ? 1 : ((k > ap2d_pkg::MaxKernel) ? ap2d_pkg::MaxKernel : int'(k));
    ss = (s == 0) ? 1 : int'(s);
    if (n > 64) n = 64;
    span = n + 2 * int'(pad[2:0]);
    return (span < kk) ? 0 : (span - kk) / ss + 1;
  endfunction

  // Loads an h by w plane; with ragged set, rows above the last are longer.
  task automatic load_plane(int h, int w, bit ragged, bit noisy);
    int rw;
    for (int r = 0; r < h; r++) begin
      rw = (ragged && r != h - 1) ? w + $urandom_range(3, 1) : w;
      for (int c = 0; c < rw; c++) begin
        if (noisy && $urandom_range(15) == 0)
          send_word(1'b1, 16'($urandom), 1'($urandom), 1'($urandom));
        if (r == h - 1 && c == rw - 1)
          send_word(1'b0, 16'($urandom), 1'($urandom), 1'b1);
        else
          send_word(1'b0, 16'($urandom), c == rw - 1, 1'b0);
      end
    end
  endtask

  // Asks for n output words, with random mark bits riding along.
  task automatic request_outputs(int n);
    for (int i = 0; i < n; i++)
      send_word(1'b1, 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic plane_and_outputs(int h, int w, bit ragged, int extra);
    int n;
    load_plane(h, w, ragged, 1'b0);
    n = axis_outputs(h, cur_cfg[ap2d_pkg::RegPadTop], cur_cfg[ap2d_pkg::RegKernelH],
                     cur_cfg[ap2d_pkg::RegStrideR]) *
        axis_outputs(w, cur_cfg[ap2d_pkg::RegPadLeft], cur_cfg[ap2d_pkg::RegKernelW],
                     cur_cfg[ap2d_pkg::RegStrideC]);
    if (n > 24) n = 24;
    request_outputs(n + extra);
  endtask

  initial begin
    int h, w, n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full-scale samples, request while loading, request after the last word.
    set_config(1, 1, 1, 1, 0, 0, 0);
    send_word(1'b1, 16'h7fff, 1'b1, 1'b1);
    send_word(1'b0, 16'h8000, 1'b0, 1'b0);
    send_word(1'b0, 16'h7fff, 1'b1, 1'b1);
    request_outputs(3);
    drain();
    // Largest kernel, stride and padding with padded taps counted.
    set_config(8, 8, 8, 8, 7, 7, 1);
    plane_and_outputs(1, 1, 1'b0, 1);
    drain();
    // Windows entirely in padding give a zero divisor.
    set_config(1, 1, 7, 7, 7, 7, 0);
    plane_and_outputs(1, 1, 1'b0, 0);
    drain();
    // Kernel zero and kernel above the maximum, stride zero, ragged rows.
    set_config(0, 15, 0, 0, 0, 0, 0);
    plane_and_outputs(2, 8, 1'b1, 0);
    drain();
    // Plane smaller than the kernel stays in loading.
    set_config(8, 8, 1, 1, 0, 0, 0);
    plane_and_outputs(1, 1, 1'b0, 2);
    drain();
    // Rows and planes past the maximum size.
    set_config(8, 8, 8, 8, 0, 0, 1);
    plane_and_outputs(1, 66, 1'b0, 0);
    plane_and_outputs(66, 1, 1'b0, 0);
    drain();

    // Random phases: new settings, then one to three planes of random content.
    while (words_sent < 380) begin
      gaps_on = !(words_sent > 180 && words_sent < 280);
      if ($urandom_range(3) == 0)
        set_config($urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(2, 1),
                   $urandom_range(2, 1), $urandom_range(1), $urandom_range(1),
                   $urandom_range(1));
      else
        set_config($urandom_range(15), $urandom_range(15), $urandom_range(15),
                   $urandom_range(15), $urandom_range(7), $urandom_range(7),
                   $urandom_range(1));
      repeat ($urandom_range(3, 1)) begin
        h = $urandom_range(5, 1);
        w = $urandom_range(6, 1);
        case ($urandom_range(9))
          0: begin
            // Abandon emission part way by loading the next plane.
            load_plane(h, w, 1'b0, 1'b1);
            n = axis_outputs(h, cur_cfg[ap2d_pkg::RegPadTop], cur_cfg[ap2d_pkg::RegKernelH],
                             cur_cfg[ap2d_pkg::RegStrideR]) *
                axis_outputs(w, cur_cfg[ap2d_pkg::RegPadLeft], cur_cfg[ap2d_pkg::RegKernelW],
                             cur_cfg[ap2d_pkg::RegStrideC]);
            request_outputs(n / 2);
          end
          1: plane_and_outputs(h, w, 1'b1, $urandom_range(1));
          default: plane_and_outputs(h, w, 1'b0, 0);
        endcase
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_average_pool_2d passed");
    end else begin
      $display("tb_average_pool_2d failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ap2d_pkg.sv
hw/rtl/ap2d_datapath.sv
hw/rtl/ap2d_ctrl.sv
hw/rtl/average_pool_2d.sv
dv/ap2d_checker.sv
dv/tb_average_pool_2d.sv
